@@ rtl/core/prd_pkg.sv @@
// Shared types, widths and helper functions for the point-to-ray distance unit.
// Depends on nothing; every other file in rtl/core imports it.
`timescale 1ns / 1ps

package prd_pkg;

  localparam int SqWidth   = 62;  // squared distance, Q24.24 with headroom
  localparam int SqrtBits  = 31;  // result bits of the integer square root
  localparam int DistWidth = 52;

  typedef logic signed [23:0] coord_t;
  typedef logic signed [15:0] dir_t;

  // Moved point and moved origin
  typedef struct packed {
    logic   opcode;
    coord_t px;
    coord_t py;
    coord_t pz;
    coord_t ox;
    coord_t oy;
    coord_t oz;
  } moved_t;

  // Projection result, squared distance still unsaturated
  typedef struct packed {
    logic                opcode;
    logic [SqWidth-1:0]  sq;
    logic [22:0]         ray_param;
    coord_t              cx;
    coord_t              cy;
    coord_t              cz;
  } proj_t;

  // One word inside the square root pipeline
  typedef struct packed {
    logic                 opcode;
    logic [SqWidth-1:0]   rem;
    logic [SqrtBits-1:0]  root;
    logic [DistWidth-1:0] sq_sat;
    logic [22:0]          ray_param;
    coord_t               cx;
    coord_t               cy;
    coord_t               cz;
  } isq_t;

  // Finished result word
  typedef struct packed {
    logic                 opcode;
    logic [DistWidth-1:0] distance;
    logic [22:0]          ray_param;
    coord_t               cx;
    coord_t               cy;
    coord_t               cz;
  } res_t;

  function automatic coord_t sat24(input logic signed [33:0] x);
    if (x > 34'sd8388607) begin
      return 24'sh7fffff;
    end else if (x < -34'sd8388608) begin
      return 24'sh800000;
    end
    return 24'(x);
  endfunction

  // pos + floor((prod + 2^7) / 2^8), saturated to 24 bits
  function automatic coord_t move_coord(input coord_t pos, input logic signed [40:0] prod);
    logic signed [41:0] rnd;
    logic signed [33:0] sum;
    rnd = 42'(prod) + 42'sd128;
    sum = 34'(pos) + 34'(rnd >>> 8);
    return sat24(sum);
  endfunction

endpackage

@@ rtl/core/prd_motion.sv @@
// Motion section: scales both velocities by the move time and adds them on.
// Two register stages; uses prd_pkg.
`timescale 1ns / 1ps

module prd_motion
  import prd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic         opcode,
  input  logic [15:0]  move_time,
  input  coord_t       point_x,
  input  coord_t       point_y,
  input  coord_t       point_z,
  input  coord_t       point_vel_x,
  input  coord_t       point_vel_y,
  input  coord_t       point_vel_z,
  input  coord_t       origin_vel_x,
  input  coord_t       origin_vel_y,
  input  coord_t       origin_vel_z,
  input  coord_t       origin_x,
  input  coord_t       origin_y,
  input  coord_t       origin_z,
  output logic         out_valid,
  input  logic         out_ready,
  output moved_t       out_word
);

  logic v1;
  logic v2;
  logic adv1;
  logic adv2;

  logic               op1;
  coord_t             pos1 [3];
  logic signed [40:0] mul_p1 [3];
  logic signed [40:0] mul_o1 [3];

  coord_t             pos_in [3];
  coord_t             pvel_in [3];
  coord_t             ovel_in [3];
  coord_t             org [3];
  logic signed [16:0] t_s;

  moved_t word2;

  assign pos_in  = '{point_x, point_y, point_z};
  assign pvel_in = '{point_vel_x, point_vel_y, point_vel_z};
  assign ovel_in = '{origin_vel_x, origin_vel_y, origin_vel_z};
  assign org     = '{origin_x, origin_y, origin_z};
  assign t_s     = $signed({1'b0, move_time});

  assign adv2     = !v2 || out_ready;
  assign adv1     = !v1 || adv2;
  assign in_ready = adv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (adv1) begin
        v1 <= in_valid;
      end
      if (adv2) begin
        v2 <= v1;
      end
    end
  end

  // stage 1: time times velocity
  always_ff @(posedge clk) begin
    if (adv1 && in_valid) begin
      op1 <= opcode;
      for (int i = 0; i < 3; i++) begin
        pos1[i]   <= pos_in[i];
        mul_p1[i] <= t_s * pvel_in[i];
        mul_o1[i] <= t_s * ovel_in[i];
      end
    end
  end

  // stage 2: round, add position, saturate
  always_ff @(posedge clk) begin
    if (adv2 && v1) begin
      word2.opcode <= op1;
      word2.px     <= move_coord(pos1[0], mul_p1[0]);
      word2.py     <= move_coord(pos1[1], mul_p1[1]);
      word2.pz     <= move_coord(pos1[2], mul_p1[2]);
      word2.ox     <= move_coord(org[0], mul_o1[0]);
      word2.oy     <= move_coord(org[1], mul_o1[1]);
      word2.oz     <= move_coord(org[2], mul_o1[2]);
    end
  end

  assign out_valid = v2;
  assign out_word  = word2;

endmodule

@@ rtl/core/prd_project.sv @@
// Projection section: ray parameter, clamp, closest point and squared distance.
// Six register stages; uses prd_pkg.
`timescale 1ns / 1ps

module prd_project
  import prd_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  moved_t in_word,
  input  dir_t   dir_x,
  input  dir_t   dir_y,
  input  dir_t   dir_z,
  output logic   out_valid,
  input  logic   out_ready,
  output proj_t  out_word
);

  localparam int Stages = 6;

  logic [Stages-1:0] v;
  logic [Stages:0]   adv;

  dir_t   dir [3];
  coord_t p_in [3];
  coord_t o_in [3];

  // stage A: dot product terms
  logic               op_a;
  coord_t             p_a [3];
  coord_t             o_a [3];
  logic signed [40:0] dp_a [3];
  // stage B: clamped parameter
  logic               op_b;
  coord_t             p_b [3];
  coord_t             o_b [3];
  logic [27:0]        par_b;
  // stage C: parameter times direction
  logic               op_c;
  coord_t             p_c [3];
  coord_t             o_c [3];
  logic [22:0]        rp_c;
  logic signed [44:0] pd_c [3];
  // stage D: closest point and error magnitude
  logic               op_d;
  logic [22:0]        rp_d;
  coord_t             c_d [3];
  logic [29:0]        ae_d [3];
  // stage E: squares
  logic               op_e;
  logic [22:0]        rp_e;
  coord_t             c_e [3];
  logic [59:0]        sq_e [3];
  // stage F: sum
  proj_t              word_f;

  logic signed [42:0] dot_sum;
  logic signed [28:0] par_raw;
  logic signed [29:0] c_full [3];
  logic signed [30:0] e_full [3];
  logic signed [45:0] pd_rnd [3];

  assign dir  = '{dir_x, dir_y, dir_z};
  assign p_in = '{in_word.px, in_word.py, in_word.pz};
  assign o_in = '{in_word.ox, in_word.oy, in_word.oz};

  assign adv[Stages] = out_ready;
  for (genvar k = 0; k < Stages; k++) begin : g_adv
    assign adv[k] = !v[k] || adv[k+1];
  end
  assign in_ready = adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[0]) begin
        v[0] <= in_valid;
      end
      for (int k = 1; k < Stages; k++) begin
        if (adv[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  assign dot_sum = 43'(dp_a[0]) + 43'(dp_a[1]) + 43'(dp_a[2]) + 43'sd8192;
  assign par_raw = 29'(dot_sum >>> 14);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pd_rnd[i] = 46'(pd_c[i]) + 46'sd8192;
      c_full[i] = 30'(o_c[i]) + 30'(pd_rnd[i] >>> 14);
      e_full[i] = 31'(c_full[i]) - 31'(p_c[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0] && in_valid) begin
      op_a <= in_word.opcode;
      for (int i = 0; i < 3; i++) begin
        p_a[i]  <= p_in[i];
        o_a[i]  <= o_in[i];
        dp_a[i] <= dir[i] * (25'(p_in[i]) - 25'(o_in[i]));
      end
    end
    if (adv[1] && v[0]) begin
      op_b  <= op_a;
      p_b   <= p_a;
      o_b   <= o_a;
      // a parameter that is not positive clamps to the origin
      par_b <= (par_raw <= 29'sd0) ? 28'd0 : par_raw[27:0];
    end
    if (adv[2] && v[1]) begin
      op_c <= op_b;
      p_c  <= p_b;
      o_c  <= o_b;
      rp_c <= (|par_b[27:23]) ? 23'h7fffff : par_b[22:0];
      for (int i = 0; i < 3; i++) begin
        pd_c[i] <= $signed({1'b0, par_b}) * dir[i];
      end
    end
    if (adv[3] && v[2]) begin
      op_d <= op_c;
      rp_d <= rp_c;
      for (int i = 0; i < 3; i++) begin
        c_d[i]  <= sat24(34'(c_full[i]));
        ae_d[i] <= e_full[i][30] ? 30'(-e_full[i]) : 30'(e_full[i]);
      end
    end
    if (adv[4] && v[3]) begin
      op_e <= op_d;
      rp_e <= rp_d;
      c_e  <= c_d;
      for (int i = 0; i < 3; i++) begin
        sq_e[i] <= ae_d[i] * ae_d[i];
      end
    end
    if (adv[5] && v[4]) begin
      word_f.opcode    <= op_e;
      word_f.ray_param <= rp_e;
      word_f.cx        <= c_e[0];
      word_f.cy        <= c_e[1];
      word_f.cz        <= c_e[2];
      word_f.sq        <= SqWidth'(sq_e[0]) + SqWidth'(sq_e[1]) + SqWidth'(sq_e[2]);
    end
  end

  assign out_valid = v[Stages-1];
  assign out_word  = word_f;

endmodule

@@ rtl/core/prd_isqrt.sv @@
// Square root section: restoring integer square root, one result bit per stage.
// SqrtBits register stages; uses prd_pkg.
`timescale 1ns / 1ps

module prd_isqrt
  import prd_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  proj_t in_word,
  output logic  out_valid,
  input  logic  out_ready,
  output res_t  out_word
);

  logic [SqrtBits-1:0] vld;
  logic [SqrtBits:0]   adv;
  isq_t                stage_w [SqrtBits];
  isq_t                entry;
  isq_t                last;

  always_comb begin
    entry           = '0;
    entry.opcode    = in_word.opcode;
    entry.rem       = in_word.sq;
    entry.root      = '0;
    entry.sq_sat    = (|in_word.sq[SqWidth-1:DistWidth]) ? {DistWidth{1'b1}}
                                                         : in_word.sq[DistWidth-1:0];
    entry.ray_param = in_word.ray_param;
    entry.cx        = in_word.cx;
    entry.cy        = in_word.cy;
    entry.cz        = in_word.cz;
  end

  assign adv[SqrtBits] = out_ready;
  assign in_ready      = adv[0];

  for (genvar k = 0; k < SqrtBits; k++) begin : g_stage
    localparam int B = SqrtBits - 1 - k;

    isq_t              src;
    isq_t              nxt;
    isq_t              w_q;
    logic              src_v;
    logic              v_q;
    logic [SqWidth-1:0] trial;

    if (k == 0) begin : g_first
      assign src   = entry;
      assign src_v = in_valid;
    end else begin : g_next
      assign src   = stage_w[k-1];
      assign src_v = vld[k-1];
    end

    // (2*root + 2^B) * 2^B with root holding only bits above B
    assign trial = (SqWidth'(src.root) << (B + 1)) | (SqWidth'(1) << (2 * B));

    always_comb begin
      nxt = src;
      if (src.rem >= trial) begin
        nxt.rem  = src.rem - trial;
        nxt.root = src.root | (SqrtBits'(1) << B);
      end
    end

    assign adv[k] = !v_q || adv[k+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q <= 1'b0;
      end else if (adv[k]) begin
        v_q <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (adv[k] && src_v) begin
        w_q <= nxt;
      end
    end

    assign vld[k]     = v_q;
    assign stage_w[k] = w_q;
  end

  assign last = stage_w[SqrtBits-1];

  assign out_valid          = vld[SqrtBits-1];
  assign out_word.opcode    = last.opcode;
  assign out_word.distance  = last.opcode ? DistWidth'(last.root) : last.sq_sat;
  assign out_word.ray_param = last.ray_param;
  assign out_word.cx        = last.cx;
  assign out_word.cy        = last.cy;
  assign out_word.cz        = last.cz;

endmodule

@@ rtl/core/point_ray_distance_3d_unit.sv @@
// Top level of the point-to-ray distance unit: configuration registers and
// the three pipeline sections. Uses prd_pkg, prd_motion, prd_project, prd_isqrt.
`timescale 1ns / 1ps

// Usage
//   Query words enter on in_valid/in_ready, one word per handshake; result
//   words leave on out_valid/out_ready, exactly one result per query, in
//   order. The ray origin and direction sit in six registers written through
//   cfg_write/cfg_index/cfg_data (index 0..2 origin x/y/z, 3..5 direction
//   x/y/z, higher indices ignored); write them only while the pipe is empty.
//   The pipe holds 2 stages of motion, 6 stages of projection and squared
//   distance, and 31 stages of square root, one root bit per stage.
//   Throughput is one word per cycle while out_ready is high: every stage
//   holds a valid bit and advances whenever the stage after it is free, so
//   bubbles close up and in_ready stays high until all 39 stages are full.
//   When the receiver stalls, hold the last word on the output and back the
//   stall up stage by stage; nothing is dropped or repeated.
//   Reset (rst, synchronous) empties every stage and loads origin (0,0,0)
//   and direction (1,0,0).
module point_ray_distance_3d_unit
  import prd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data,
  // query channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        opcode,
  input  coord_t      point_x,
  input  coord_t      point_y,
  input  coord_t      point_z,
  input  logic [15:0] move_time,
  input  coord_t      point_vel_x,
  input  coord_t      point_vel_y,
  input  coord_t      point_vel_z,
  input  coord_t      origin_vel_x,
  input  coord_t      origin_vel_y,
  input  coord_t      origin_vel_z,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [51:0] distance_value,
  output logic [22:0] ray_param,
  output coord_t      closest_x,
  output coord_t      closest_y,
  output coord_t      closest_z
);

  localparam logic [2:0] RegOriginX = 3'd0;
  localparam logic [2:0] RegOriginY = 3'd1;
  localparam logic [2:0] RegOriginZ = 3'd2;
  localparam logic [2:0] RegDirX    = 3'd3;
  localparam logic [2:0] RegDirY    = 3'd4;
  localparam logic [2:0] RegDirZ    = 3'd5;

  coord_t origin_x;
  coord_t origin_y;
  coord_t origin_z;
  dir_t   dir_x;
  dir_t   dir_y;
  dir_t   dir_z;

  logic   mov_valid;
  logic   mov_ready;
  moved_t mov_word;
  logic   proj_valid;
  logic   proj_ready;
  proj_t  proj_word;
  res_t   res_word;

  // Configuration registers; the user must change them only while the pipe is
  // empty, which the block does not enforce, so the stages that use them read them directly.
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x <= '0;
      origin_y <= '0;
      origin_z <= '0;
      dir_x    <= 16'sd16384;
      dir_y    <= '0;
      dir_z    <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        RegOriginX: origin_x <= cfg_data;
        RegOriginY: origin_y <= cfg_data;
        RegOriginZ: origin_z <= cfg_data;
        RegDirX:    dir_x    <= cfg_data[15:0];
        RegDirY:    dir_y    <= cfg_data[15:0];
        RegDirZ:    dir_z    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Advance point and origin along their velocities
  prd_motion u_motion (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .opcode       (opcode),
    .move_time    (move_time),
    .point_x      (point_x),
    .point_y      (point_y),
    .point_z      (point_z),
    .point_vel_x  (point_vel_x),
    .point_vel_y  (point_vel_y),
    .point_vel_z  (point_vel_z),
    .origin_vel_x (origin_vel_x),
    .origin_vel_y (origin_vel_y),
    .origin_vel_z (origin_vel_z),
    .origin_x     (origin_x),
    .origin_y     (origin_y),
    .origin_z     (origin_z),
    .out_valid    (mov_valid),
    .out_ready    (mov_ready),
    .out_word     (mov_word)
  );

  // Project onto the ray, clamp behind the origin, square the error
  prd_project u_project (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mov_valid),
    .in_ready  (mov_ready),
    .in_word   (mov_word),
    .dir_x     (dir_x),
    .dir_y     (dir_y),
    .dir_z     (dir_z),
    .out_valid (proj_valid),
    .out_ready (proj_ready),
    .out_word  (proj_word)
  );

  // Root on request, saturate the squared form otherwise
  prd_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (proj_valid),
    .in_ready  (proj_ready),
    .in_word   (proj_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (res_word)
  );

  assign distance_value = res_word.distance;
  assign ray_param      = res_word.ray_param;
  assign closest_x      = res_word.cx;
  assign closest_y      = res_word.cy;
  assign closest_z      = res_word.cz;

  // In the cycle after reset, neither proj_valid nor out_valid is high
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid && !proj_valid)
    else $error("pipeline not empty after reset");

  // The squared distance never reaches the top two bits of its register
  a_sq_headroom: assert property (@(posedge clk) disable iff (rst)
    proj_valid |-> proj_word.sq[SqWidth-1:SqWidth-2] == 2'b00)
    else $error("squared distance overflowed its headroom");

  // A root result fits in the root width
  a_root_width: assert property (@(posedge clk) disable iff (rst)
    out_valid && res_word.opcode |-> distance_value[DistWidth-1:SqrtBits] == '0)
    else $error("square root result too wide");

endmodule
